### src/bda_pkg.sv
`timescale 1ns / 1ps

package bda_pkg;

  // Number of button lanes and width of each hold counter.
  localparam int NUM_BUTTONS = 3;
  localparam int COUNT_WIDTH = 16;

  // Widths of the stream fields and of the configuration registers.
  localparam int FIELD_WIDTH = 3;
  localparam int CFG_WIDTH   = 16;
  localparam int TDATA_WIDTH = 8;

  // Configuration register indexes.
  localparam logic REG_INITIAL_DELAY = 1'b0;
  localparam logic REG_REPEAT_PERIOD = 1'b1;

  // Button phase codes.
  localparam logic [1:0] PH_UP       = 2'd0;
  localparam logic [1:0] PH_DOWN     = 2'd1;
  localparam logic [1:0] PH_PRESSED  = 2'd2;
  localparam logic [1:0] PH_REPEAT   = 2'd3;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [CFG_WIDTH-1:0]   cfg_word_t;

  // Per-tick status of one button after its update.
  typedef struct packed {
    logic press;
    logic held;
  } btn_status_t;

endpackage

### src/bda_button.sv
`timescale 1ns / 1ps

module bda_button
  import bda_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        tick,
  input  logic        level,
  input  cfg_word_t   initial_delay,
  input  cfg_word_t   repeat_period,
  output btn_status_t status
);

  logic [1:0] phase_r, phase_nxt;
  count_t     count_r, count_nxt;
  count_t     count_inc;
  count_t     delay_cnt;
  count_t     period_cnt;

  assign count_inc  = count_r + count_t'(1);
  assign delay_cnt  = count_t'(initial_delay);
  assign period_cnt = count_t'(repeat_period);

  always_comb begin
    phase_nxt    = phase_r;
    count_nxt    = count_r;
    status.press = 1'b0;
    if (level) begin
      case (phase_r)
        PH_UP: begin
          phase_nxt = PH_DOWN;
        end
        PH_DOWN: begin
          phase_nxt    = PH_PRESSED;
          status.press = 1'b1;
        end
        PH_PRESSED: begin
          // The count is compared after the increment, so a delay of zero
          // only matches after the counter wraps.
          if (count_inc == delay_cnt) begin
            count_nxt = '0;
            phase_nxt = PH_REPEAT;
          end else begin
            count_nxt = count_inc;
          end
        end
        PH_REPEAT: begin
          if (count_inc == period_cnt) begin
            count_nxt    = '0;
            status.press = 1'b1;
          end else begin
            count_nxt = count_inc;
          end
        end
        default: begin
          phase_nxt = PH_UP;
          count_nxt = '0;
        end
      endcase
    end else begin
      phase_nxt = PH_UP;
      count_nxt = '0;
    end
    status.held = (phase_nxt == PH_PRESSED) || (phase_nxt == PH_REPEAT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_UP;
      count_r <= '0;
    end else if (tick) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

### src/button_debounce_autorepeat.sv
`timescale 1ns / 1ps

// Debouncer with auto-repeat for a small group of push buttons.
// Each request on the in_ channel is one sample tick: in_tdata[2:0] holds the
// sampled button levels. Every tick yields exactly one result on the out_
// channel: out_tdata[2:0] is the mask of presses signaled in that tick and
// out_tdata[5:3] the mask of buttons in pressed or repeating phase.
// A button signals one press on its second consecutive high sample, then
// after initial_delay further high ticks starts repeating, with one press
// every repeat_period ticks. A low sample returns it to up.
// Each accepted tick's result is registered in the output register; a tick can be
// accepted every cycle while in_tready is high.
// When the receiver stalls, one more tick is taken into a skid register;
// in_tready then drops until the output drains.
// Reset puts every button in up phase, clears counters and results, and
// loads initial_delay = 50 and repeat_period = 10. The user writes the registers
// via cfg_we/cfg_addr/cfg_wdata while no tick is in flight, unchecked by the block.

module button_debounce_autorepeat
  import bda_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [TDATA_WIDTH-1:0] in_tdata,   // [2:0] button_levels
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [TDATA_WIDTH-1:0] out_tdata,  // [2:0] press_mask, [5:3] held_mask
  input  logic                   cfg_we,
  input  logic                   cfg_addr,
  input  cfg_word_t              cfg_wdata
);

  localparam int RES_WIDTH = 2 * FIELD_WIDTH;

  cfg_word_t initial_delay_r, repeat_period_r;

  logic                 tick;
  btn_status_t          status [NUM_BUTTONS];
  logic [FIELD_WIDTH-1:0] press_mask, held_mask;
  logic [RES_WIDTH-1:0] result;

  logic                 out_valid_r, out_valid_nxt;
  logic [RES_WIDTH-1:0] out_data_r, out_data_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  logic [RES_WIDTH-1:0] skid_data_r, skid_data_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      initial_delay_r <= cfg_word_t'(50);
      repeat_period_r <= cfg_word_t'(10);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_INITIAL_DELAY: initial_delay_r <= cfg_wdata;
        REG_REPEAT_PERIOD: repeat_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_tready = !skid_valid_r;
  assign tick      = in_tvalid && in_tready;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    logic level;
    if (i < FIELD_WIDTH) begin : g_sampled
      assign level = in_tdata[i];
    end else begin : g_unsampled
      assign level = 1'b0;
    end
    bda_button u_button (
      .clk           (clk),
      .rst_n         (rst_n),
      .tick          (tick),
      .level         (level),
      .initial_delay (initial_delay_r),
      .repeat_period (repeat_period_r),
      .status        (status[i])
    );
  end

  for (genvar i = 0; i < FIELD_WIDTH; i++) begin : g_mask
    if (i < NUM_BUTTONS) begin : g_used
      assign press_mask[i] = status[i].press;
      assign held_mask[i]  = status[i].held;
    end else begin : g_unused
      assign press_mask[i] = 1'b0;
      assign held_mask[i]  = 1'b0;
    end
  end

  assign result = {held_mask, press_mask};

  // Output register with one skid entry behind it.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    skid_valid_nxt = skid_valid_r;
    skid_data_nxt  = skid_data_r;
    if (!out_valid_r || out_tready) begin
      if (skid_valid_r) begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end else begin
        out_valid_nxt = tick;
        out_data_nxt  = result;
      end
    end else if (tick) begin
      skid_valid_nxt = 1'b1;
      skid_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(TDATA_WIDTH - RES_WIDTH)'(0), out_data_r};

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output register is empty");

  a_press_is_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r[FIELD_WIDTH-1:0] & ~out_data_r[RES_WIDTH-1:FIELD_WIDTH]) == '0))
    else $error("press signaled for a button that is not held");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> (!out_tvalid && in_tready))
    else $error("result channel not idle after reset");

  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && tick) |=> (skid_valid_r && !in_tready))
    else $error("stalled request did not land in the skid entry");
`endif

endmodule
